// ===== src/sseq_pkg.sv =====
`timescale 1ns / 1ps
package sseq_pkg;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PAST  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

// ===== src/sseq_req_if.sv =====
`timescale 1ns / 1ps
interface sseq_req_if #(
   parameter int TS_BITS = 48,
   parameter int ID_BITS = 32
);
   logic               valid;
   logic               ready;
   logic               kind;
   logic [TS_BITS-1:0] entry_ts;
   logic [ID_BITS-1:0] entry_id;

   modport source (output valid, output kind, output entry_ts, output entry_id, input ready);
   modport sink   (input valid, input kind, input entry_ts, input entry_id, output ready);
endinterface

// ===== src/sseq_rsp_if.sv =====
`timescale 1ns / 1ps
interface sseq_rsp_if #(
   parameter int TS_BITS  = 48,
   parameter int ID_BITS  = 32,
   parameter int CNT_BITS = 7
);
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [TS_BITS-1:0]  popped_ts;
   logic [ID_BITS-1:0]  popped_id;
   logic [TS_BITS-1:0]  min_ts;
   logic [TS_BITS-1:0]  max_ts;
   logic [CNT_BITS-1:0] occupancy;

   modport source (output valid, output status, output popped_ts, output popped_id,
                   output min_ts, output max_ts, output occupancy, input ready);
   modport sink   (input valid, input status, input popped_ts, input popped_id,
                   input min_ts, input max_ts, input occupancy, output ready);
endinterface

// ===== src/sseq_cell.sv =====
`timescale 1ns / 1ps
module sseq_cell #(
   parameter int TS_BITS = 48,
   parameter int ID_BITS = 32
) (
   input  logic                  clock,
   input  sseq_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  logic                  occ_left,
   input  logic                  gt_left,
   input  logic [TS_BITS-1:0]    new_ts,
   input  logic [ID_BITS-1:0]    new_id,
   input  logic [TS_BITS-1:0]    left_ts,
   input  logic [ID_BITS-1:0]    left_id,
   input  logic [TS_BITS-1:0]    right_ts,
   input  logic [ID_BITS-1:0]    right_id,
   output logic [TS_BITS-1:0]    ts,
   output logic [ID_BITS-1:0]    id,
   output logic                  gt
);
   import sseq_pkg::*;

   logic [TS_BITS-1:0] ts_ff;
   logic [TS_BITS-1:0] ts_in;
   logic [ID_BITS-1:0] id_ff;
   logic [ID_BITS-1:0] id_in;
   logic               insert;

   // An entry moves right only if it is strictly later than the new one.
   assign gt     = occ && (ts_ff > new_ts);
   assign insert = !gt_left && (gt || !occ) && occ_left;

   always_comb begin
      ts_in = ts_ff;
      id_in = id_ff;
      priority if (ctl.pop) begin
         ts_in = right_ts;
         id_in = right_id;
      end else if (ctl.push && gt_left) begin
         ts_in = left_ts;
         id_in = left_id;
      end else if (ctl.push && insert) begin
         ts_in = new_ts;
         id_in = new_id;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff <= ts_in;
      id_ff <= id_in;
   end

   assign ts = ts_ff;
   assign id = id_ff;

endmodule

// ===== src/stable_sorted_event_queue.sv =====
`timescale 1ns / 1ps
// Channel    Interface     Role    Beat contents
// req_chan   sseq_req_if   sink    kind, entry_ts, entry_id
// rsp_chan   sseq_rsp_if   source  status, popped_ts, popped_id, min_ts, max_ts, occupancy
//
// For each accepted beat, every cell of the sorted chain compares and shifts in
// parallel, and the response is registered, appearing in the cycle after the request.
// A new request is taken in the same cycle that a waiting response is taken, so
// the block sustains one beat per cycle; a stalled response holds the request side.
// Synchronous reset empties the queue and clears the last dequeued time; no clearing pass.
module stable_sorted_event_queue #(
   parameter int CAPACITY = 64,
   parameter int TS_BITS  = 48,
   parameter int ID_BITS  = 32
) (
   input logic        clock,
   input logic        reset,
   sseq_req_if.sink   req_chan,
   sseq_rsp_if.source rsp_chan
);
   import sseq_pkg::*;

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [TS_BITS-1:0]  last_deq_ff;
   logic [TS_BITS-1:0]  last_deq_in;
   logic [TS_BITS-1:0]  tail_ff;
   logic [TS_BITS-1:0]  tail_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;
   logic [TS_BITS-1:0]  popped_ts_ff;
   logic [TS_BITS-1:0]  popped_ts_in;
   logic [ID_BITS-1:0]  popped_id_ff;
   logic [ID_BITS-1:0]  popped_id_in;
   logic [TS_BITS-1:0]  min_ts_ff;
   logic [TS_BITS-1:0]  min_ts_in;
   logic [TS_BITS-1:0]  max_ts_ff;
   logic [TS_BITS-1:0]  max_ts_in;

   logic                accept;
   logic                is_push;
   logic                past;
   logic                full;
   logic                do_push;
   logic                do_pop;
   logic [TS_BITS-1:0]  head_in;
   cell_ctl_type        ctl;

   logic [TS_BITS-1:0]  cell_ts [CAPACITY];
   logic [ID_BITS-1:0]  cell_id [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] cell_occ;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept  = req_chan.valid && req_chan.ready;
   assign is_push = (req_chan.kind == KIND_PUSH);
   assign past    = req_chan.entry_ts < last_deq_ff;
   assign full    = (count_ff == CNT_BITS'(CAPACITY));
   assign do_push = accept && is_push && !past && !full;
   assign do_pop  = accept && !is_push && (count_ff != '0);
   assign ctl     = '{push: do_push, pop: do_pop};

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [TS_BITS-1:0] l_ts;
         logic [ID_BITS-1:0] l_id;
         logic [TS_BITS-1:0] r_ts;
         logic [ID_BITS-1:0] r_id;
         logic               l_gt;
         logic               l_occ;

         assign cell_occ[gi] = count_ff > CNT_BITS'(gi);

         if (gi == 0) begin : g_first
            assign l_ts  = '0;
            assign l_id  = '0;
            assign l_gt  = 1'b0;
            assign l_occ = 1'b1;
         end else begin : g_mid
            assign l_ts  = cell_ts[gi-1];
            assign l_id  = cell_id[gi-1];
            assign l_gt  = cell_gt[gi-1];
            assign l_occ = cell_occ[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign r_ts = cell_ts[gi];
            assign r_id = cell_id[gi];
         end else begin : g_inner
            assign r_ts = cell_ts[gi+1];
            assign r_id = cell_id[gi+1];
         end

         sseq_cell #(
            .TS_BITS(TS_BITS),
            .ID_BITS(ID_BITS)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .occ      (cell_occ[gi]),
            .occ_left (l_occ),
            .gt_left  (l_gt),
            .new_ts   (req_chan.entry_ts),
            .new_id   (req_chan.entry_id),
            .left_ts  (l_ts),
            .left_id  (l_id),
            .right_ts (r_ts),
            .right_id (r_id),
            .ts       (cell_ts[gi]),
            .id       (cell_id[gi]),
            .gt       (cell_gt[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      last_deq_in  = last_deq_ff;
      tail_in      = tail_ff;
      head_in      = cell_ts[0];
      popped_ts_in = '0;
      popped_id_in = '0;
      status_in    = ST_OK;
      if (is_push) begin
         priority if (past) begin
            status_in = ST_PAST;
         end else if (full) begin
            status_in = ST_FULL;
         end
      end else if (count_ff == '0) begin
         status_in = ST_EMPTY;
      end
      if (do_push) begin
         count_in = count_ff + CNT_BITS'(1);
         if ((count_ff == '0) || (req_chan.entry_ts >= tail_ff)) begin
            tail_in = req_chan.entry_ts;
         end
         if ((count_ff == '0) || cell_gt[0]) begin
            head_in = req_chan.entry_ts;
         end
      end else if (do_pop) begin
         count_in     = count_ff - CNT_BITS'(1);
         last_deq_in  = cell_ts[0];
         popped_ts_in = cell_ts[0];
         popped_id_in = cell_id[0];
         head_in      = cell_ts[1];
      end
      if (count_in == '0) begin
         min_ts_in = last_deq_in;
         max_ts_in = last_deq_in;
      end else begin
         min_ts_in = head_in;
         max_ts_in = tail_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_deq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_deq_ff  <= last_deq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      if (accept) begin
         status_ff    <= status_in;
         popped_ts_ff <= popped_ts_in;
         popped_id_ff <= popped_id_in;
         min_ts_ff    <= min_ts_in;
         max_ts_ff    <= max_ts_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.popped_ts = popped_ts_ff;
   assign rsp_chan.popped_id = popped_id_ff;
   assign rsp_chan.min_ts    = min_ts_ff;
   assign rsp_chan.max_ts    = max_ts_ff;
   assign rsp_chan.occupancy = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("occupancy exceeds capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("accepted push did not add an entry");

   a_pop_time: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> last_deq_ff == $past(cell_ts[0]))
      else $error("pop did not record the head time");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_BITS'(2)) |-> (cell_ts[0] <= cell_ts[1]))
      else $error("head entries out of order");

endmodule
